/* rtl/core/pkgate_pkg.sv */
// ----------------------------------------------------------------------------
// pkgate_pkg
// Shared types and constants for the pose keyframe gate.
// ----------------------------------------------------------------------------
package pkgate_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int SUM_BITS_DEF   = 40;

    localparam int DTHR_W = 23;
    localparam int TTHR_W = 16;
    localparam int HEAD_W = 16;

    localparam logic [DTHR_W-1:0] DTHR_RST = 23'd2048;
    localparam logic [TTHR_W-1:0] TTHR_RST = 16'd910;

    localparam logic [HEAD_W-1:0] HALF_TURN = 16'h8000;

    // register index, taken from paddr[2]
    localparam logic REG_DIST = 1'b0;
    localparam logic REG_TURN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_ROOT,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

endpackage

/* rtl/core/pose_keyframe_gate_top.sv */
// ----------------------------------------------------------------------------
// pose_keyframe_gate_top
// Keyframe gate on a pose stream: distance and turn thresholds against the
// last kept pose, with saturating path length and climb totals.
//
//   channel  dir  transaction
//   s_       in   pose: pos_x, pos_y, pos_z, heading
//   m_       out  keyframe: kept_x, kept_y, kept_z, path_length, climb_total
//   apb      in   distance_threshold (0x0), turn_threshold (0x4)
//
// A pose passes in order through the accept state, the difference state, the
// shared squarer, the iterative square root and its done flag, and the
// decision state.
// The first pose after reset is only stored as the reference, not emitted.
// Reset is synchronous, active low; totals and reference are cleared.
// A held keyframe on m_ only stalls the decision cycle of the next keyframe.
// ----------------------------------------------------------------------------
module pose_keyframe_gate_top #(
    parameter int COORD_BITS = pkgate_pkg::COORD_BITS_DEF,
    parameter int SUM_BITS   = pkgate_pkg::SUM_BITS_DEF,
    localparam int IN_W  = ((3 * COORD_BITS + pkgate_pkg::HEAD_W + 7) / 8) * 8,
    localparam int OUT_W = ((3 * COORD_BITS + 2 * SUM_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // pos_x, pos_y, pos_z, heading

    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // kept_x, kept_y, kept_z, path_length, climb_total

    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW  = COORD_BITS;
    localparam int SW  = SUM_BITS;
    localparam int HW  = pkgate_pkg::HEAD_W;
    localparam int RW  = CW + 1;
    localparam int AW  = 2 * RW;
    localparam int DW  = (RW > pkgate_pkg::DTHR_W) ? RW : pkgate_pkg::DTHR_W;
    localparam int XW  = ((SW > RW) ? SW : RW) + 1;
    localparam logic [1:0] SQ_LAST = 2'd3;

    // configuration
    logic [pkgate_pkg::DTHR_W-1:0] dthr_reg;
    logic [pkgate_pkg::TTHR_W-1:0] tthr_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dthr_reg <= pkgate_pkg::DTHR_RST;
            tthr_reg <= pkgate_pkg::TTHR_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                pkgate_pkg::REG_DIST: dthr_reg <= pwdata[pkgate_pkg::DTHR_W-1:0];
                pkgate_pkg::REG_TURN: tthr_reg <= pwdata[pkgate_pkg::TTHR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pkgate_pkg::REG_DIST: prdata = 32'(dthr_reg);
            pkgate_pkg::REG_TURN: prdata = 32'(tthr_reg);
            default:              prdata = '0;
        endcase
    end

    // input fields
    logic signed [CW-1:0] s_x, s_y, s_z;
    logic        [HW-1:0] s_h;

    assign s_x = s_tdata[CW-1:0];
    assign s_y = s_tdata[2*CW-1:CW];
    assign s_z = s_tdata[3*CW-1:2*CW];
    assign s_h = s_tdata[3*CW+HW-1:3*CW];

    // sequencer
    pkgate_pkg::state_t state_reg, state_next;
    logic               s_acc;
    logic               keep;
    logic               out_free;
    logic               commit;
    logic               root_start;
    logic [1:0]         sq_cnt_reg;
    pkgate_pkg::root_stat_t root_stat;

    logic have_ref_reg;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pkgate_pkg::ST_IDLE: begin
                if (s_tvalid && have_ref_reg) begin
                    state_next = pkgate_pkg::ST_DIFF;
                end
            end
            pkgate_pkg::ST_DIFF:   state_next = pkgate_pkg::ST_SQUARE;
            pkgate_pkg::ST_SQUARE: begin
                if (sq_cnt_reg == SQ_LAST) begin
                    state_next = pkgate_pkg::ST_ROOT;
                end
            end
            pkgate_pkg::ST_ROOT: begin
                if (root_stat.done) begin
                    state_next = pkgate_pkg::ST_DECIDE;
                end
            end
            pkgate_pkg::ST_DECIDE: begin
                if (!keep || out_free) begin
                    state_next = pkgate_pkg::ST_IDLE;
                end
            end
            default: state_next = pkgate_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        root_start = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            pkgate_pkg::ST_IDLE:   s_tready   = 1'b1;
            pkgate_pkg::ST_SQUARE: root_start = (sq_cnt_reg == SQ_LAST);
            pkgate_pkg::ST_DECIDE: commit     = keep && out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pkgate_pkg::ST_IDLE;
            have_ref_reg <= 1'b0;
            sq_cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (s_acc) begin
                have_ref_reg <= 1'b1;
            end
            if (state_reg == pkgate_pkg::ST_SQUARE) begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end else begin
                sq_cnt_reg <= '0;
            end
        end
    end

    // pose and reference
    logic signed [CW-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic        [HW-1:0] cur_h_reg;
    logic signed [CW-1:0] ref_x_reg, ref_y_reg, ref_z_reg;
    logic        [HW-1:0] ref_h_reg;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cur_x_reg <= s_x;
            cur_y_reg <= s_y;
            cur_z_reg <= s_z;
            cur_h_reg <= s_h;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= '0;
            ref_h_reg <= '0;
        end else if (s_acc && !have_ref_reg) begin
            ref_x_reg <= s_x;
            ref_y_reg <= s_y;
            ref_z_reg <= s_z;
            ref_h_reg <= s_h;
        end else if (commit) begin
            ref_x_reg <= cur_x_reg;
            ref_y_reg <= cur_y_reg;
            ref_z_reg <= cur_z_reg;
            ref_h_reg <= cur_h_reg;
        end
    end

    // differences
    logic signed [CW:0] dx, dy, dz;
    logic        [CW-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic        [HW-1:0] dh;
    logic        [HW-1:0] yaw_reg;

    assign dx = (CW+1)'(cur_x_reg) - (CW+1)'(ref_x_reg);
    assign dy = (CW+1)'(cur_y_reg) - (CW+1)'(ref_y_reg);
    assign dz = (CW+1)'(cur_z_reg) - (CW+1)'(ref_z_reg);
    assign dh = cur_h_reg - ref_h_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == pkgate_pkg::ST_DIFF) begin
            mag_x_reg <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
            mag_y_reg <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
            mag_z_reg <= dz[CW] ? CW'(-dz) : dz[CW-1:0];
            yaw_reg   <= (dh > pkgate_pkg::HALF_TURN) ? HW'(-dh) : dh;
        end
    end

    // shared squarer and accumulator
    logic [CW-1:0]   mag_sel;
    logic [2*CW-1:0] sq_reg;
    logic [AW-1:0]   acc_reg;
    logic [AW-1:0]   acc_sum;

    always_comb begin
        case (sq_cnt_reg)
            2'd0:    mag_sel = mag_x_reg;
            2'd1:    mag_sel = mag_y_reg;
            default: mag_sel = mag_z_reg;
        endcase
    end

    assign acc_sum = acc_reg + AW'(sq_reg);

    always_ff @(posedge aclk) begin
        if (state_reg == pkgate_pkg::ST_DIFF) begin
            acc_reg <= '0;
        end else if (state_reg == pkgate_pkg::ST_SQUARE) begin
            sq_reg <= mag_sel * mag_sel;
            if (sq_cnt_reg != 2'd0) begin
                acc_reg <= acc_sum;
            end
        end
    end

    logic [RW-1:0] travel;

    pkgate_isqrt #(
        .RW (RW)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (acc_sum),
        .root     (travel),
        .stat     (root_stat)
    );

    assign keep = (DW'(travel) >= DW'(dthr_reg)) || (yaw_reg >= tthr_reg);

    // totals
    logic [SW-1:0] len_sum_reg, climb_sum_reg;
    logic [XW-1:0] len_add, climb_add;
    logic [SW-1:0] len_sat, climb_sat;

    assign len_add   = XW'(len_sum_reg) + XW'(travel);
    assign climb_add = XW'(climb_sum_reg) + XW'(mag_z_reg);
    assign len_sat   = (len_add[XW-1:SW] != '0) ? '1 : len_add[SW-1:0];
    assign climb_sat = (climb_add[XW-1:SW] != '0) ? '1 : climb_add[SW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_sum_reg   <= '0;
            climb_sum_reg <= '0;
        end else if (commit) begin
            len_sum_reg   <= len_sat;
            climb_sum_reg <= climb_sat;
        end
    end

    // output register
    logic                 m_valid_reg;
    logic signed [CW-1:0] kept_x_reg, kept_y_reg, kept_z_reg;
    logic        [SW-1:0] path_reg, climb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            kept_x_reg <= cur_x_reg;
            kept_y_reg <= cur_y_reg;
            kept_z_reg <= cur_z_reg;
            path_reg   <= len_sat;
            climb_reg  <= climb_sat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({climb_reg, path_reg, kept_z_reg, kept_y_reg, kept_x_reg});

endmodule

/* rtl/core/pkgate_isqrt.sv */
// ----------------------------------------------------------------------------
// pkgate_isqrt
// Iterative integer square root, one result bit per cycle (floor).
// ----------------------------------------------------------------------------
module pkgate_isqrt #(
    parameter int RW = pkgate_pkg::COORD_BITS_DEF + 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [2*RW-1:0]        radicand,
    output logic [RW-1:0]          root,
    output pkgate_pkg::root_stat_t stat
);

    localparam int AW = 2 * RW;
    localparam int CNT_W = $clog2(RW + 1);

    logic [AW-1:0]    rem_reg;
    logic [AW-1:0]    res_reg;
    logic [AW-1:0]    bit_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [AW-1:0] trial;
    logic          fits;

    assign trial = res_reg + bit_reg;
    assign fits  = (rem_reg >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(RW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= radicand;
            res_reg <= '0;
            bit_reg <= AW'(1) << (AW - 2);
        end else if (cnt_reg != '0) begin
            if (fits) begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root      = res_reg[RW-1:0];
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule
